>>> src/spu_pkg.sv
// Package for the sounder packet sample unpacker.
// Holds the shared constants and the item type that the front end passes
// to the back end through the queue. No dependencies.
`default_nettype none

package spu_pkg;

  // Default packet geometry.
  localparam int unsigned Channels           = 20;
  localparam int unsigned Elements           = 56;
  localparam int unsigned MinPacketBytes     = 2320;
  localparam int unsigned ElementStrideBytes = 36;

  // Fixed sample format.
  localparam int unsigned WordBits     = 13;
  localparam int unsigned HeadSkipBits = 26 + 8 * 12 + 3;
  localparam logic [12:0] MidValue     = 13'd4096;
  localparam logic [11:0] MagMask      = 12'hFFF;

  // Depth of the queue between the front end and the back end.
  localparam int unsigned QueueDepth = 4;

  // One classified input byte: which of its bits are sample bits, and
  // where a sample word completes, with the tags of that sample.
  typedef struct packed {
    logic [7:0]  data;
    logic [7:0]  mask;
    logic        done;
    logic [2:0]  done_bit;
    logic [4:0]  channel;
    logic [5:0]  element;
    logic [15:0] line;
    logic        last;
  } item_t;

endpackage

`default_nettype wire

>>> src/spu_front.sv
// Front end of the sample unpacker: tracks the bit position in the packet,
// checks the packet length and classifies each byte's bits.
// Depends on spu_pkg.
`default_nettype none

module spu_front #(
  parameter int unsigned CHANNELS             = spu_pkg::Channels,
  parameter int unsigned ELEMENTS             = spu_pkg::Elements,
  parameter int unsigned MIN_PACKET_BYTES     = spu_pkg::MinPacketBytes,
  parameter int unsigned ELEMENT_STRIDE_BYTES = spu_pkg::ElementStrideBytes
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          first_byte_i,
  input  wire logic [15:0]   packet_length_i,
  output spu_pkg::item_t     item_o,
  output logic               item_push_o
);

  localparam int unsigned StrideBits = 8 * ELEMENT_STRIDE_BYTES;
  localparam int unsigned DataBits   = CHANNELS * spu_pkg::WordBits;

  localparam logic [8:0]  RelLast  = 9'(StrideBits - 1);
  localparam logic [8:0]  DataEnd  = 9'(DataBits);
  localparam logic [4:0]  ChanLast = 5'(CHANNELS - 1);
  localparam logic [5:0]  ElemLast = 6'(ELEMENTS - 1);
  localparam logic [15:0] MinLen   = 16'(MIN_PACKET_BYTES);
  localparam logic [6:0]  HeadSkip = 7'(spu_pkg::HeadSkipBits);
  localparam logic [3:0]  WordLast = 4'(spu_pkg::WordBits - 1);

  logic        active_q, active_d;
  logic [6:0]  hpos_q, hpos_d;
  logic [8:0]  rel_q, rel_d;
  logic [5:0]  elem_q, elem_d;
  logic [4:0]  chan_q, chan_d;
  logic [3:0]  wcnt_q, wcnt_d;
  logic [15:0] line_q, line_d;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // Walk the eight bits of the byte, MSB first, through the position counters.
  always_comb begin
    logic [2:0] bidx;
    active_d = active_q;
    hpos_d   = hpos_q;
    rel_d    = rel_q;
    elem_d   = elem_q;
    chan_d   = chan_q;
    wcnt_d   = wcnt_q;
    line_d   = line_q;
    item_o          = '0;
    item_o.data     = data_byte_i;
    bidx            = 3'd0;

    if (accept_i) begin
      // A first byte closes any open packet and checks the new length.
      if (first_byte_i) begin
        if (active_q) begin
          line_d = sat_inc(line_q);
        end
        active_d = (packet_length_i >= MinLen);
        hpos_d   = 7'd0;
        rel_d    = 9'd0;
        elem_d   = 6'd0;
        chan_d   = 5'd0;
        wcnt_d   = 4'd0;
      end

      for (int i = 0; i < 8; i++) begin
        bidx = 3'(7 - i);
        if (active_d) begin
          if (hpos_d < HeadSkip) begin
            hpos_d = hpos_d + 7'd1;
          end else begin
            // Sample bits of the current element.
            if (rel_d < DataEnd) begin
              item_o.mask[bidx] = 1'b1;
              if (wcnt_d == WordLast) begin
                item_o.done     = 1'b1;
                item_o.done_bit = bidx;
                item_o.channel  = chan_d;
                item_o.element  = elem_d;
                item_o.line     = line_d;
                item_o.last     = (chan_d == ChanLast) && (elem_d == ElemLast);
                wcnt_d          = 4'd0;
                chan_d          = chan_d + 5'd1;
                if (item_o.last) begin
                  active_d = 1'b0;
                  line_d   = sat_inc(line_d);
                end
              end else begin
                wcnt_d = wcnt_d + 4'd1;
              end
            end
            // End of the element's stride.
            if (active_d) begin
              if (rel_d == RelLast) begin
                rel_d  = 9'd0;
                elem_d = elem_d + 6'd1;
                chan_d = 5'd0;
                wcnt_d = 4'd0;
              end else begin
                rel_d = rel_d + 9'd1;
              end
            end
          end
        end
      end
    end
  end

  // Only bytes that carry sample bits go to the back end.
  assign item_push_o = accept_i && (item_o.mask != 8'd0);

  // Position and line registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      hpos_q   <= '0;
      rel_q    <= '0;
      elem_q   <= '0;
      chan_q   <= '0;
      wcnt_q   <= '0;
      line_q   <= '0;
    end else begin
      active_q <= active_d;
      hpos_q   <= hpos_d;
      rel_q    <= rel_d;
      elem_q   <= elem_d;
      chan_q   <= chan_d;
      wcnt_q   <= wcnt_d;
      line_q   <= line_d;
    end
  end

`ifndef ASSERT_OFF
  // The last sample of a packet is always a completed word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_push_o && item_o.last |-> item_o.done)
    else $error("last sample flagged without a completed word");
`endif

endmodule

`default_nettype wire

>>> src/spu_queue.sv
// Short queue of classified items between the front end and the back end.
// Depends on spu_pkg.
`default_nettype none

module spu_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_en_i,
  input  wire spu_pkg::item_t wr_item_i,
  input  wire logic           rd_en_i,
  output spu_pkg::item_t      rd_item_o,
  output logic                valid_o,
  output logic                full_o
);

  localparam int unsigned Depth = spu_pkg::QueueDepth;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  spu_pkg::item_t   mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  count_q;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    ptr_next = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign valid_o   = (count_q != '0);
  assign full_o    = (count_q == CntW'(Depth));
  assign rd_item_o = mem_q[rptr_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wptr_q] <= wr_item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (wr_en_i) begin
        wptr_q <= ptr_next(wptr_q);
      end
      if (rd_en_i) begin
        rptr_q <= ptr_next(rptr_q);
      end
      if (wr_en_i && !rd_en_i) begin
        count_q <= count_q + CntW'(1);
      end else if (rd_en_i && !wr_en_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

`ifndef ASSERT_OFF
  // No write into a full queue and no read from an empty one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en_i |-> !full_o) and (rd_en_i |-> valid_o))
    else $error("queue overflow or underflow");

  // The fill count never passes the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

>>> src/spu_back.sv
// Back end of the sample unpacker: shifts sample bits into a word history,
// converts completed sign-magnitude words and holds the result register.
// Depends on spu_pkg.
`default_nettype none

module spu_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire spu_pkg::item_t item_i,
  input  wire logic           item_valid_i,
  output logic                item_take_o,
  input  wire logic           pop,
  output logic                empty,
  output logic [12:0]         sample_value_o,
  output logic [4:0]          channel_index_o,
  output logic [5:0]          element_index_o,
  output logic [15:0]         line_index_o,
  output logic                last_sample_o
);

  logic        out_valid_q, out_valid_d;
  logic [11:0] hist_q, hist_d;
  logic [12:0] word;
  logic [12:0] value;
  logic [12:0] value_q;
  logic [4:0]  chan_q;
  logic [5:0]  elem_q;
  logic [15:0] line_q;
  logic        last_q;

  // Take the next item whenever the result register is free or being read.
  assign item_take_o = item_valid_i && (!out_valid_q || pop);

  // Shift the byte's sample bits in order; a word is its last 13 sample bits.
  always_comb begin
    logic [12:0] shifted;
    logic [2:0]  bidx;
    hist_d  = hist_q;
    word    = '0;
    shifted = '0;
    bidx    = 3'd0;
    for (int i = 0; i < 8; i++) begin
      bidx = 3'(7 - i);
      if (item_i.mask[bidx]) begin
        shifted = {hist_d, item_i.data[bidx]};
        if (item_i.done && (item_i.done_bit == bidx)) begin
          word = shifted;
        end
        hist_d = shifted[11:0];
      end
    end
  end

  // Sign-magnitude word to offset value.
  always_comb begin
    logic [11:0] mag;
    mag   = word[11:0] & spu_pkg::MagMask;
    value = word[12] ? spu_pkg::MidValue + {1'b0, mag}
                     : spu_pkg::MidValue - {1'b0, mag};
  end

  // Result register valid.
  always_comb begin
    out_valid_d = out_valid_q;
    if (item_take_o && item_i.done) begin
      out_valid_d = 1'b1;
    end else if (pop && out_valid_q) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Word history and result payload.
  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      hist_q <= hist_d;
      if (item_i.done) begin
        value_q <= value;
        chan_q  <= item_i.channel;
        elem_q  <= item_i.element;
        line_q  <= item_i.line;
        last_q  <= item_i.last;
      end
    end
  end

  assign empty           = !out_valid_q;
  assign sample_value_o  = value_q;
  assign channel_index_o = chan_q;
  assign element_index_o = elem_q;
  assign line_index_o    = line_q;
  assign last_sample_o   = last_q;

`ifndef ASSERT_OFF
  // A taken item with a completed word always shows a result next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_take_o && item_i.done |=> out_valid_q)
    else $error("completed word did not reach the result register");

  // The completing bit of a word is itself a sample bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_i && item_i.done |-> item_i.mask[item_i.done_bit])
    else $error("word completes on a bit that is not a sample bit");
`endif

endmodule

`default_nettype wire

>>> src/sounder_packet_sample_unpacker_top.sv
// Sample unpacker: one payload byte per cycle in, one result per completed word out.
// A byte that completes a word goes through the queue and then into the result register.
// Throughput: one byte per cycle; the front end classifies all eight bits of a byte at once.
// The input stalls only when the four-entry queue is full, which needs an unread result.
// Reset (rst_ni, asynchronous, active low) empties the queue, goes idle, clears the line count.
// Depends on spu_pkg, spu_front, spu_queue and spu_back.
`default_nettype none

module sounder_packet_sample_unpacker_top #(
  parameter int unsigned CHANNELS             = spu_pkg::Channels,
  parameter int unsigned ELEMENTS             = spu_pkg::Elements,
  parameter int unsigned MIN_PACKET_BYTES     = spu_pkg::MinPacketBytes,
  parameter int unsigned ELEMENT_STRIDE_BYTES = spu_pkg::ElementStrideBytes
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          first_byte_i,
  input  wire logic [15:0]   packet_length_i,
  output logic               empty,
  input  wire logic          pop,
  output logic [12:0]        sample_value_o,
  output logic [4:0]         channel_index_o,
  output logic [5:0]         element_index_o,
  output logic [15:0]        line_index_o,
  output logic               last_sample_o
);

  logic           accept;
  logic           q_push;
  logic           q_valid;
  logic           q_take;
  spu_pkg::item_t front_item;
  spu_pkg::item_t q_item;

  // A byte is taken when it is pushed and the queue has room.
  assign accept = push && !full;

  spu_front #(
    .CHANNELS            (CHANNELS),
    .ELEMENTS            (ELEMENTS),
    .MIN_PACKET_BYTES    (MIN_PACKET_BYTES),
    .ELEMENT_STRIDE_BYTES(ELEMENT_STRIDE_BYTES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (data_byte_i),
    .first_byte_i   (first_byte_i),
    .packet_length_i(packet_length_i),
    .item_o         (front_item),
    .item_push_o    (q_push)
  );

  spu_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (q_push),
    .wr_item_i(front_item),
    .rd_en_i  (q_take),
    .rd_item_o(q_item),
    .valid_o  (q_valid),
    .full_o   (full)
  );

  spu_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (q_item),
    .item_valid_i   (q_valid),
    .item_take_o    (q_take),
    .pop            (pop),
    .empty          (empty),
    .sample_value_o (sample_value_o),
    .channel_index_o(channel_index_o),
    .element_index_o(element_index_o),
    .line_index_o   (line_index_o),
    .last_sample_o  (last_sample_o)
  );

endmodule

`default_nettype wire
